FILE: hdl/pot_pkg.sv
// shared types, constants and codes of the periodic and one-shot timer table
`default_nettype none

package pot_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > 4) ? CNT_W : 4;

    // results reported per tick
    localparam int RESULT_CAP  = 16;
    localparam int RCNT_W      = $clog2(RESULT_CAP + 1);

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request type codes on the input tuser
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_REG    = 2'd1;
    localparam logic [1:0] REQ_SETDUE = 2'd2;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [RCNT_W-1:0] t_rcnt;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ONCE = 2'd1,
        MODE_LOOP = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_TICK,
        K_REG,
        K_SETDUE
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_REG,
        S_SETDUE,
        S_FLUSH
    } t_state;

    // classified request: tval is now_time for a tick, due_time for set-due
    typedef struct packed {
        t_kind       kind;
        logic [31:0] tval;
        logic [15:0] cb;
        t_mode       mode;
        logic [31:0] per;
        logic [3:0]  idx;
    } t_req;

    // queue status toward the front
    typedef struct packed {
        logic full;
        logic valid;
    } t_qstat;

endpackage

`default_nettype wire

FILE: hdl/periodic_oneshot_timer_table.sv
// Timer table top level: one request per transaction, results as a stream.
// Order: an accepted request is written into the queue and the engine pops it when idle;
// a set-due result is then loaded into the output register once that register is free.
// A tick walks one entry per cycle while the output register can take its reports;
// a registration walks the table in the same way; a full output register stalls the walk.
// Up to two requests wait in the queue; synchronous active-low reset empties the table.
`default_nettype none

module periodic_oneshot_timer_table (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [1:0]    i_s_tuser,   // req_type
    // now_time[31:0], callback_id[47:32], timer_mode[49:48], period[81:50],
    // entry_index[85:82], due_time[117:86], zero[119:118]
    input  wire logic [119:0]  i_s_tdata,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic               o_m_tuser,   // fired
    output logic [7:0]         o_m_tdata,   // result_index[3:0], status[5:4], zero[7:6]
    output logic               o_m_tlast    // last_result
);

    pot_pkg::t_qstat qstat;
    pot_pkg::t_req   push_data;
    pot_pkg::t_req   pop_data;
    logic            push;
    logic            pop;

    // accept and classify
    pot_front u_front (
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // request queue
    pot_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_qstat     (qstat),
        .o_pop_data  (pop_data)
    );

    // table engine
    pot_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (qstat),
        .i_req      (pop_data),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tuser  (o_m_tuser),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

FILE: hdl/pot_front.sv
// front end: accepts request transactions and classifies them for the queue
`default_nettype none

module pot_front (
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [1:0]    i_s_tuser,   // req_type
    // now_time[31:0], callback_id[47:32], timer_mode[49:48], period[81:50],
    // entry_index[85:82], due_time[117:86], zero[119:118]
    input  wire logic [119:0]  i_s_tdata,
    input  wire pot_pkg::t_qstat i_qstat,
    output logic               o_push,
    output pot_pkg::t_req      o_push_data
);

    logic [1:0]     mode_raw;
    pot_pkg::t_mode mode_clean;
    logic           known;

    assign o_s_tready = !i_qstat.full;
    assign mode_raw   = i_s_tdata[49:48];

    // unknown mode codes are stored as off
    always_comb begin
        case (mode_raw)
            2'(pot_pkg::MODE_ONCE): mode_clean = pot_pkg::MODE_ONCE;
            2'(pot_pkg::MODE_LOOP): mode_clean = pot_pkg::MODE_LOOP;
            default:                mode_clean = pot_pkg::MODE_OFF;
        endcase
    end

    // request kind and the time field that kind uses
    always_comb begin
        known            = 1'b1;
        o_push_data.kind = pot_pkg::K_TICK;
        o_push_data.tval = i_s_tdata[31:0];
        case (i_s_tuser)
            pot_pkg::REQ_TICK: begin
                o_push_data.kind = pot_pkg::K_TICK;
                o_push_data.tval = i_s_tdata[31:0];
            end
            pot_pkg::REQ_REG: begin
                o_push_data.kind = pot_pkg::K_REG;
            end
            pot_pkg::REQ_SETDUE: begin
                o_push_data.kind = pot_pkg::K_SETDUE;
                o_push_data.tval = i_s_tdata[117:86];
            end
            default: begin
                known = 1'b0;
            end
        endcase
        o_push_data.cb   = i_s_tdata[47:32];
        o_push_data.mode = mode_clean;
        o_push_data.per  = i_s_tdata[81:50];
        o_push_data.idx  = i_s_tdata[85:82];
    end

    // unknown request types are accepted and dropped
    assign o_push = i_s_tvalid && o_s_tready && known && i_rst_n;

endmodule

`default_nettype wire

FILE: hdl/pot_queue.sv
// short request queue between the front end and the table engine
`default_nettype none

module pot_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire pot_pkg::t_req   i_push_data,
    input  wire logic            i_pop,
    output pot_pkg::t_qstat      o_qstat,
    output pot_pkg::t_req        o_pop_data
);

    pot_pkg::t_req               r_slot [pot_pkg::QUEUE_DEPTH];
    logic [pot_pkg::QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [pot_pkg::QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [pot_pkg::QCNT_W-1:0]  r_fill, n_fill;
    logic                        do_push, do_pop;

    assign o_qstat.full  = (r_fill == pot_pkg::QCNT_W'(pot_pkg::QUEUE_DEPTH));
    assign o_qstat.valid = (r_fill != '0);
    assign o_pop_data    = r_slot[r_rd_ptr];
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && o_qstat.valid;

    // pointer wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == pot_pkg::QPTR_W'(pot_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == pot_pkg::QPTR_W'(pot_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pot_back.sv
// table engine: walks the timer table for ticks and registrations, writes set-due entries by index
`default_nettype none

module pot_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pot_pkg::t_qstat i_qstat,
    input  wire pot_pkg::t_req  i_req,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic                o_m_tuser,   // fired
    output logic [7:0]          o_m_tdata,   // result_index[3:0], status[5:4], zero[7:6]
    output logic                o_m_tlast    // last_result
);

    // table storage, undefined until written
    logic [15:0]    r_cb   [pot_pkg::MAX_ENTRIES];
    pot_pkg::t_mode r_mode [pot_pkg::MAX_ENTRIES];
    logic [31:0]    r_per  [pot_pkg::MAX_ENTRIES];
    logic [31:0]    r_due  [pot_pkg::MAX_ENTRIES];

    pot_pkg::t_state  r_state, n_state;
    pot_pkg::t_req    r_cur, n_cur;
    pot_pkg::t_cnt    r_ptr, n_ptr;
    pot_pkg::t_cnt    r_count, n_count;
    logic             r_pend_valid, n_pend_valid;
    pot_pkg::t_idx    r_pend_idx, n_pend_idx;
    pot_pkg::t_rcnt   r_n, n_n;

    logic             r_out_valid, n_out_valid;
    logic             r_out_fired;
    logic [3:0]       r_out_idx;
    pot_pkg::t_status r_out_status;
    logic             r_out_last;

    logic             load_out;
    logic             out_fired;
    logic [3:0]       out_idx;
    pot_pkg::t_status out_status;
    logic             out_last;

    pot_pkg::t_idx    rd_addr;
    logic [15:0]      rd_cb;
    pot_pkg::t_mode   rd_mode;
    logic [31:0]      rd_per;
    logic [31:0]      rd_due;

    logic             wr_new, wr_mode_en, wr_per_en, wr_due_en;
    pot_pkg::t_mode   wr_mode;
    logic [31:0]      wr_due;

    logic             out_free, ptr_end, fire, idx_ok;
    logic [32:0]      sum;
    logic [31:0]      reload;

    // one read port, addressed by the walk pointer or the set-due index
    assign rd_addr = (r_state == pot_pkg::S_SETDUE) ? pot_pkg::t_idx'(r_cur.idx) :
                     r_ptr[pot_pkg::IDX_W-1:0];
    assign rd_cb   = r_cb[rd_addr];
    assign rd_mode = r_mode[rd_addr];
    assign rd_per  = r_per[rd_addr];
    assign rd_due  = r_due[rd_addr];

    assign out_free = !r_out_valid || i_m_tready;
    assign ptr_end  = (r_ptr == r_count);
    assign fire     = (rd_mode != pot_pkg::MODE_OFF) && (rd_due <= r_cur.tval);
    assign idx_ok   = (pot_pkg::CMP_W'(r_cur.idx) < pot_pkg::CMP_W'(r_count));

    // saturating reload of a periodic entry
    assign sum    = {1'b0, r_cur.tval} + {1'b0, rd_per};
    assign reload = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    // next state, table writes and result loading
    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_ptr        = r_ptr;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_n          = r_n;
        o_pop        = 1'b0;
        load_out     = 1'b0;
        out_fired    = 1'b0;
        out_idx      = 4'(r_ptr);
        out_status   = pot_pkg::ST_OK;
        out_last     = 1'b1;
        wr_new       = 1'b0;
        wr_mode_en   = 1'b0;
        wr_per_en    = 1'b0;
        wr_due_en    = 1'b0;
        wr_mode      = r_cur.mode;
        wr_due       = reload;
        case (r_state)
            pot_pkg::S_IDLE: begin
                if (i_qstat.valid) begin
                    o_pop = 1'b1;
                    n_cur = i_req;
                    n_ptr = '0;
                    n_n   = '0;
                    case (i_req.kind)
                        pot_pkg::K_TICK:   n_state = pot_pkg::S_TICK;
                        pot_pkg::K_REG:    n_state = pot_pkg::S_REG;
                        pot_pkg::K_SETDUE: n_state = pot_pkg::S_SETDUE;
                        default:           n_state = pot_pkg::S_IDLE;
                    endcase
                end
            end
            pot_pkg::S_TICK: begin
                if (ptr_end) begin
                    n_state = r_pend_valid ? pot_pkg::S_FLUSH : pot_pkg::S_IDLE;
                end else if (!fire) begin
                    n_ptr = r_ptr + 1'b1;
                end else if (!(r_pend_valid && (r_n < pot_pkg::t_rcnt'(pot_pkg::RESULT_CAP))
                               && !out_free)) begin
                    // update the due entry
                    if (rd_mode == pot_pkg::MODE_ONCE) begin
                        wr_mode_en = 1'b1;
                        wr_mode    = pot_pkg::MODE_OFF;
                    end else begin
                        wr_due_en = 1'b1;
                        wr_due    = reload;
                    end
                    // the held report is not the last one: send it on
                    if (r_n < pot_pkg::t_rcnt'(pot_pkg::RESULT_CAP)) begin
                        if (r_pend_valid) begin
                            load_out  = 1'b1;
                            out_fired = 1'b1;
                            out_idx   = 4'(r_pend_idx);
                            out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_ptr[pot_pkg::IDX_W-1:0];
                        n_n          = r_n + 1'b1;
                    end
                    n_ptr = r_ptr + 1'b1;
                end
            end
            pot_pkg::S_FLUSH: begin
                if (out_free) begin
                    load_out     = 1'b1;
                    out_fired    = 1'b1;
                    out_idx      = 4'(r_pend_idx);
                    out_last     = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = pot_pkg::S_IDLE;
                end
            end
            pot_pkg::S_REG: begin
                if (ptr_end) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = pot_pkg::S_IDLE;
                        if (r_count == pot_pkg::t_cnt'(pot_pkg::MAX_ENTRIES)) begin
                            out_idx    = '0;
                            out_status = pot_pkg::ST_FULL;
                        end else begin
                            // append at the end of the table
                            wr_new     = 1'b1;
                            wr_mode_en = 1'b1;
                            wr_per_en  = 1'b1;
                            wr_due_en  = 1'b1;
                            wr_due     = '0;
                            out_idx    = 4'(r_count);
                            n_count    = r_count + 1'b1;
                        end
                    end
                end else if (rd_cb == r_cur.cb) begin
                    if (out_free) begin
                        wr_mode_en = 1'b1;
                        wr_per_en  = 1'b1;
                        load_out   = 1'b1;
                        out_idx    = 4'(r_ptr);
                        n_state    = pot_pkg::S_IDLE;
                    end
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            pot_pkg::S_SETDUE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_idx  = r_cur.idx;
                    n_state  = pot_pkg::S_IDLE;
                    if (idx_ok) begin
                        wr_due_en = 1'b1;
                        wr_due    = r_cur.tval;
                        if (rd_mode == pot_pkg::MODE_OFF) begin
                            wr_mode_en = 1'b1;
                            wr_mode    = pot_pkg::MODE_ONCE;
                        end
                    end else begin
                        out_status = pot_pkg::ST_RANGE;
                    end
                end
            end
            default: begin
                n_state = pot_pkg::S_IDLE;
            end
        endcase
        n_out_valid = load_out ? 1'b1 : (i_m_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pot_pkg::S_IDLE;
            r_ptr        <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_n          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ptr        <= n_ptr;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_n          <= n_n;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_pend_idx <= n_pend_idx;
        if (load_out) begin
            r_out_fired  <= out_fired;
            r_out_idx    <= out_idx;
            r_out_status <= out_status;
            r_out_last   <= out_last;
        end
    end

    // table writes at the read address
    always_ff @(posedge i_clk) begin
        if (wr_new) begin
            r_cb[rd_addr] <= r_cur.cb;
        end
        if (wr_mode_en) begin
            r_mode[rd_addr] <= wr_mode;
        end
        if (wr_per_en) begin
            r_per[rd_addr] <= r_cur.per;
        end
        if (wr_due_en) begin
            r_due[rd_addr] <= wr_due;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_fired;
    assign o_m_tdata  = {2'b00, r_out_status, r_out_idx};
    assign o_m_tlast  = r_out_last;

    // walk pointer never passes the fill count
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r_count)
        else $error("walk pointer beyond entry count");

    // fill count never exceeds the table size
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pot_pkg::t_cnt'(pot_pkg::MAX_ENTRIES))
        else $error("entry count beyond table size");

    // a held fire report exists only during a tick walk or its flush
    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == pot_pkg::S_TICK || r_state == pot_pkg::S_FLUSH))
        else $error("held report outside a tick");

    // flush always has a report to send
    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pot_pkg::S_FLUSH) |-> r_pend_valid)
        else $error("flush without held report");

endmodule

`default_nettype wire
